// ----- hw/rtl/mpv_pkg.sv -----
// Shared types, widths and codes for the polyphonic MIDI to CV voice unit.
package mpv_pkg;

  localparam int VOICE_COUNT_DEF = 4;
  localparam int OUT_VOICES      = 4;

  localparam int CMD_W   = 8;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int PITCH_W = 16;
  localparam int OCT_W   = 4;
  localparam int SEMI_W  = 5;
  localparam int CENT_W  = 8;

  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 80;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_OCTAVE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEMITONE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENT     = 2'd2;

  // MIDI status high nibbles
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

  localparam logic [PITCH_W-1:0] CENTS_PER_OCTAVE   = 16'd1200;
  localparam logic [PITCH_W-1:0] CENTS_PER_SEMITONE = 16'd100;

  typedef struct packed {
    logic [VEL_W-1:0]  vel;
    logic [NOTE_W-1:0] note;
    logic [CMD_W-1:0]  cmd;
  } midi_msg_t;

endpackage

// ----- hw/rtl/mpv_voice_alloc.sv -----
// Voice slot state and note-on / note-off allocation.
module mpv_voice_alloc import mpv_pkg::*; #(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                apply,
  input  midi_msg_t                           msg,
  output logic [VOICE_COUNT-1:0][NOTE_W-1:0]  note_next,
  output logic [VOICE_COUNT-1:0]              active_next,
  output logic [VEL_W-1:0]                    vel_next
);

  logic [VOICE_COUNT-1:0][NOTE_W-1:0] voice_note;
  logic [VOICE_COUNT-1:0]             voice_active;
  logic [VEL_W-1:0]                   held_velocity;

  logic                   is_on;
  logic                   is_off;
  logic [VOICE_COUNT-1:0] match;
  logic [VOICE_COUNT-1:0] free_ok;
  logic [VOICE_COUNT-1:0] on_pick;
  logic [VOICE_COUNT-1:0] off_pick;

  // Decode status and compare the note against every slot
  always_comb begin
    is_on  = (msg.cmd[7:4] == STATUS_NOTE_ON);
    is_off = (msg.cmd[7:4] == STATUS_NOTE_OFF);
    for (int i = 0; i < VOICE_COUNT; i++) begin
      match[i] = (voice_note[i] == msg.note);
    end
    // A slot is usable when idle and no other slot holds the same note
    for (int i = 0; i < VOICE_COUNT; i++) begin
      free_ok[i] = !voice_active[i] &&
                   ((match & ~(VOICE_COUNT'(1) << i)) == '0);
    end
    // Isolate the lowest set bit
    on_pick  = free_ok & (~free_ok + VOICE_COUNT'(1));
    off_pick = match & (~match + VOICE_COUNT'(1));
  end

  // Next slot state and held velocity
  always_comb begin
    note_next   = voice_note;
    active_next = voice_active;
    vel_next    = held_velocity;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (is_on && on_pick[i]) begin
        note_next[i]   = msg.note;
        active_next[i] = 1'b1;
      end
      if (is_off && off_pick[i]) begin
        note_next[i]   = '0;
        active_next[i] = 1'b0;
      end
    end
    if (is_on && (on_pick != '0)) begin
      vel_next = msg.vel;
    end
    if (active_next == '0) begin
      vel_next = '0;
    end
  end

  // Commit the update once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_note    <= '0;
      voice_active  <= '0;
      held_velocity <= '0;
    end else if (apply) begin
      voice_note    <= note_next;
      voice_active  <= active_next;
      held_velocity <= vel_next;
    end
  end

endmodule

// ----- hw/rtl/mpv_cv_out.sv -----
// Pitch, gate and velocity formatting into the result register.
module mpv_cv_out import mpv_pkg::*; #(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic                                out_ready,
  input  logic [VOICE_COUNT-1:0][NOTE_W-1:0]  notes,
  input  logic [VOICE_COUNT-1:0]              active,
  input  logic [VEL_W-1:0]                    vel,
  input  logic [PITCH_W-1:0]                  base,
  output logic                                out_valid,
  output logic [OUT_TDATA_W-1:0]              out_data
);

  logic [OUT_VOICES-1:0][PITCH_W-1:0] pitch;
  logic [OUT_VOICES-1:0]              gates;

  // Voice k shows slot k when that slot exists, else note 0 with a clear gate
  for (genvar k = 0; k < OUT_VOICES; k++) begin : g_voice
    if (k < VOICE_COUNT) begin : g_slot
      assign pitch[k] = base + PITCH_W'(notes[k]) * CENTS_PER_SEMITONE;
      assign gates[k] = active[k];
    end else begin : g_none
      assign pitch[k] = base;
      assign gates[k] = 1'b0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {(OUT_TDATA_W - VEL_W - OUT_VOICES - OUT_VOICES * PITCH_W)'(0),
                   vel, gates, pitch};
    end
  end

endmodule

// ----- hw/rtl/midi_poly_voice_to_cv_unit.sv -----
// Top level of the polyphonic MIDI to CV voice unit.
//
//   channel  direction  handshake          payload, lowest bit first
//   s_       in         s_tvalid/s_tready  cmd[7:0] note_number[14:8] note_velocity[21:15]
//   m_       out        m_tvalid/m_tready  pitch one..four [63:0], gate_bits[67:64],
//                                          velocity_level[74:68]
//   cfg_     in         cfg_we             cfg_addr index, cfg_wdata value
//
// One item per cycle sustained while the output is not stalled. An item sits in
// the input register; the slot update and pitch adds then load the result
// register as the item drains. The input register drains whenever the
// result register is empty or being taken, so a stalled output holds one
// result plus one pending item. rst is synchronous and clears all voices.
module midi_poly_voice_to_cv_unit import mpv_pkg::*; #(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // cmd, note_number, note_velocity
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // pitch_cv_one..four, gate_bits, velocity_level
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic              in_valid;
  midi_msg_t         in_msg;
  logic              advance;
  logic              s_accept;

  logic [OCT_W-1:0]  octave_offset;
  logic [SEMI_W-1:0] semitone_offset;
  logic [CENT_W-1:0] cent_offset;
  logic [PITCH_W-1:0] base;

  logic [VOICE_COUNT-1:0][NOTE_W-1:0] note_next;
  logic [VOICE_COUNT-1:0]             active_next;
  logic [VEL_W-1:0]                   vel_next;

  // Handshake: drain the input register whenever the result register frees
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_msg <= midi_msg_t'(s_tdata[CMD_W+NOTE_W+VEL_W-1:0]);
    end
  end

  // Tuning registers
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_offset   <= '0;
      semitone_offset <= '0;
      cent_offset     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OCTAVE:   octave_offset   <= cfg_wdata[OCT_W-1:0];
        REG_SEMITONE: semitone_offset <= cfg_wdata[SEMI_W-1:0];
        REG_CENT:     cent_offset     <= cfg_wdata[CENT_W-1:0];
        default:      ;
      endcase
    end
  end

  // Common pitch offset in cents, two's complement modulo 2^16
  assign base = {{(PITCH_W-OCT_W){octave_offset[OCT_W-1]}}, octave_offset} * CENTS_PER_OCTAVE
              + {{(PITCH_W-SEMI_W){semitone_offset[SEMI_W-1]}}, semitone_offset}
                * CENTS_PER_SEMITONE
              + {{(PITCH_W-CENT_W){cent_offset[CENT_W-1]}}, cent_offset};

  mpv_voice_alloc #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_alloc (
    .clk         (clk),
    .rst         (rst),
    .apply       (advance),
    .msg         (in_msg),
    .note_next   (note_next),
    .active_next (active_next),
    .vel_next    (vel_next)
  );

  mpv_cv_out #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_cv_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .out_ready (m_tready),
    .notes     (note_next),
    .active    (active_next),
    .vel       (vel_next),
    .base      (base),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule
